[src/tensor_index_offset_unit_defines.svh]
// ----------------------------------------------------------------------------
// tensor index offset unit assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TENSOR_INDEX_OFFSET_UNIT_DEFINES_SVH
`define TENSOR_INDEX_OFFSET_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TIO_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TIO_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TIO_ASSERT_IMP(lbl, ante, cons, msg)
`define TIO_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[src/tio_pkg.sv]
// ----------------------------------------------------------------------------
// tio_pkg
// widths and shared types of the tensor index offset unit
// ----------------------------------------------------------------------------
`default_nettype none

package tio_pkg;

   localparam int DATA_W = 64;
   localparam int MAG_W = DATA_W - 1;
   localparam int HALF_W = DATA_W / 2;
   localparam int ACC_W = 2 * DATA_W;
   localparam int TOTAL_DIV_LOG2 = 3;
   localparam int MUL_STEPS = 4;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] a;
      logic [MAG_W-1:0] b;
      logic [MAG_W-1:0] addend;
   } tio_mul_cmd_type;

   typedef struct packed {
      logic             done;
      logic             overflow;
      logic [MAG_W-1:0] product;
   } tio_mul_res_type;

endpackage

`default_nettype wire

[src/tio_channels.sv]
// ----------------------------------------------------------------------------
// tio channels
// valid/ready channel interfaces for shape items and offset results
// ----------------------------------------------------------------------------
`default_nettype none

interface tio_req_if;
   import tio_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] dim_size;
   logic signed [DATA_W-1:0] index_value;
   logic                     has_index;
   logic                     last_dim;

   modport source (output valid, dim_size, index_value, has_index, last_dim, input ready);
   modport sink (input valid, dim_size, index_value, has_index, last_dim, output ready);
endinterface

interface tio_rsp_if;
   import tio_pkg::*;

   logic             valid;
   logic             ready;
   logic             ok;
   logic [MAG_W-1:0] offset;
   logic [MAG_W-1:0] slice_count;

   modport source (output valid, ok, offset, slice_count, input ready);
   modport sink (input valid, ok, offset, slice_count, output ready);
endinterface

`default_nettype wire

[src/tio_mul.sv]
// ----------------------------------------------------------------------------
// tio_mul
// iterative 63x63 multiply-add with overflow flag, one 32x32 partial
// product per cycle into a 128-bit accumulator
// ----------------------------------------------------------------------------
`default_nettype none
`include "tensor_index_offset_unit_defines.svh"

module tio_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  tio_pkg::tio_mul_cmd_type cmd,
   output tio_pkg::tio_mul_res_type res
);
   import tio_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] count_ff, count_in;
   logic [MAG_W-1:0]     a_ff, a_in;
   logic [MAG_W-1:0]     b_ff, b_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [DATA_W-1:0]    pp_ff, pp_in;
   logic [1:0]           shift_ff, shift_in;
   logic [HALF_W-1:0]    a_half;
   logic [HALF_W-1:0]    b_half;
   logic [ACC_W-1:0]     acc_term;

   // partial product select
   always_comb begin
      a_half = count_ff[1] ? HALF_W'(a_ff[MAG_W-1:HALF_W]) : a_ff[HALF_W-1:0];
      b_half = count_ff[0] ? HALF_W'(b_ff[MAG_W-1:HALF_W]) : b_ff[HALF_W-1:0];
      pp_in = DATA_W'(a_half) * DATA_W'(b_half);
      shift_in = {1'b0, count_ff[0]} + {1'b0, count_ff[1]};
   end

   always_comb begin
      case (shift_ff)
         2'd0: acc_term = ACC_W'(pp_ff);
         2'd1: acc_term = ACC_W'(pp_ff) << HALF_W;
         2'd2: acc_term = ACC_W'(pp_ff) << (2 * HALF_W);
         default: acc_term = '0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         count_in = '0;
         a_in = cmd.a;
         b_in = cmd.b;
         acc_in = ACC_W'(cmd.addend);
      end else if (busy_ff) begin
         if (count_ff != '0) begin
            acc_in = acc_ff + acc_term;
         end
         if (count_ff == MUL_CNT_W'(MUL_STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      pp_ff <= pp_in;
      shift_ff <= shift_in;
   end

   assign res.done = done_ff;
   assign res.overflow = |acc_ff[ACC_W-1:MAG_W];
   assign res.product = acc_ff[MAG_W-1:0];

   `TIO_ASSERT_IMP(a_no_restart, cmd.start, !busy_ff, "multiply started while busy")
   `TIO_ASSERT_NXT(a_last_step_done, busy_ff && !cmd.start && count_ff == MUL_CNT_W'(MUL_STEPS),
      done_ff && !busy_ff, "multiply did not finish after last step")
   `TIO_ASSERT_IMP(a_done_after_busy, done_ff, $past(busy_ff), "done without a running multiply")

endmodule

`default_nettype wire

[src/tensor_index_offset_unit.sv]
// ----------------------------------------------------------------------------
// tensor_index_offset_unit
// row-major slice offset of a tensor shape given one dimension per item
//
//   channel  dir  payload                                       role
//   req_ch   in   dim_size, index_value, has_index, last_dim    shape items
//   rsp_ch   out  ok, offset, slice_count                        one per shape
//
// one item at a time, up to two multiplies per item on the shared tio_mul
// multiplier (32x32 partial products), plus a third on the last item before
// the result load
// skipped multiplies (zero dimension, failed shape) shorten an item
// synchronous reset; after reset the next item starts a new shape
// a pending transaction on rsp_ch holds only the last item's result load
// ----------------------------------------------------------------------------
`default_nettype none
`include "tensor_index_offset_unit_defines.svh"

module tensor_index_offset_unit (
   input  logic      clock,
   input  logic      reset,
   tio_req_if.sink   req_ch,
   tio_rsp_if.source rsp_ch
);
   import tio_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_TOTAL   = 8'b0000_0010,
      S_TOTAL_W = 8'b0000_0100,
      S_PART    = 8'b0000_1000,
      S_PART_W  = 8'b0001_0000,
      S_FINAL   = 8'b0010_0000,
      S_FINAL_W = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] dim_ff, dim_in;
   logic [DATA_W-1:0] idx_ff, idx_in;
   logic              has_idx_ff, has_idx_in;
   logic              last_ff, last_in;
   logic [MAG_W-1:0]  total_ff, total_in;
   logic [MAG_W-1:0]  offset_ff, offset_in;
   logic [MAG_W-1:0]  slice_ff, slice_in;
   logic              phase_ff, phase_in;
   logic              first_ff, first_in;
   logic              failed_ff, failed_in;
   logic              ok_ff, ok_in;
   logic [MAG_W-1:0]  off_res_ff, off_res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [MAG_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [MAG_W-1:0]  rsp_slice_ff, rsp_slice_in;
   tio_mul_cmd_type   mul_cmd;
   tio_mul_res_type   mul_res;
   state_type         after_part;

   tio_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .res   (mul_res)
   );

   assign after_part = last_ff ? S_FINAL : S_IDLE;

   always_comb begin
      state_in = state_ff;
      dim_in = dim_ff;
      idx_in = idx_ff;
      has_idx_in = has_idx_ff;
      last_in = last_ff;
      total_in = total_ff;
      offset_in = offset_ff;
      slice_in = slice_ff;
      phase_in = phase_ff;
      first_in = first_ff;
      failed_in = failed_ff;
      ok_in = ok_ff;
      off_res_in = off_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in = rsp_ok_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_slice_in = rsp_slice_ff;
      mul_cmd.start = 1'b0;
      mul_cmd.a = total_ff;
      mul_cmd.b = dim_ff[MAG_W-1:0];
      mul_cmd.addend = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               dim_in = $unsigned(req_ch.dim_size);
               idx_in = $unsigned(req_ch.index_value);
               has_idx_in = req_ch.has_index;
               last_in = req_ch.last_dim;
               first_in = 1'b0;
               failed_in = failed_ff || (first_ff && !req_ch.has_index)
                  || req_ch.dim_size[DATA_W-1];
               state_in = S_TOTAL;
            end
         end
         S_TOTAL: begin
            if (failed_ff) begin
               state_in = S_PART;
            end else if (dim_ff == '0) begin
               total_in = '0;
               state_in = S_PART;
            end else begin
               mul_cmd.start = 1'b1;
               state_in = S_TOTAL_W;
            end
         end
         S_TOTAL_W: begin
            if (mul_res.done) begin
               if (mul_res.overflow) begin
                  failed_in = 1'b1;
               end else begin
                  total_in = mul_res.product;
               end
               state_in = S_PART;
            end
         end
         S_PART: begin
            state_in = after_part;
            if (!failed_ff) begin
               if (has_idx_ff) begin
                  if (!phase_ff || idx_ff[DATA_W-1] || idx_ff >= dim_ff) begin
                     failed_in = 1'b1;
                  end else begin
                     mul_cmd.start = 1'b1;
                     mul_cmd.a = offset_ff;
                     mul_cmd.addend = idx_ff[MAG_W-1:0];
                     state_in = S_PART_W;
                  end
               end else begin
                  phase_in = 1'b0;
                  if (dim_ff == '0) begin
                     failed_in = 1'b1;
                  end else begin
                     mul_cmd.start = 1'b1;
                     mul_cmd.a = slice_ff;
                     state_in = S_PART_W;
                  end
               end
            end
         end
         S_PART_W: begin
            if (mul_res.done) begin
               if (mul_res.overflow) begin
                  failed_in = 1'b1;
               end else if (has_idx_ff) begin
                  offset_in = mul_res.product;
               end else begin
                  slice_in = mul_res.product;
               end
               state_in = after_part;
            end
         end
         S_FINAL: begin
            if (failed_ff || (total_ff[MAG_W-1:MAG_W-TOTAL_DIV_LOG2] != '0)
                  || slice_ff == '0) begin
               ok_in = 1'b0;
               state_in = S_DONE;
            end else begin
               mul_cmd.start = 1'b1;
               mul_cmd.a = offset_ff;
               mul_cmd.b = slice_ff;
               state_in = S_FINAL_W;
            end
         end
         S_FINAL_W: begin
            if (mul_res.done) begin
               ok_in = !mul_res.overflow && (mul_res.product < total_ff);
               off_res_in = mul_res.product;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in = ok_ff;
               rsp_offset_in = ok_ff ? off_res_ff : '0;
               rsp_slice_in = ok_ff ? slice_ff : '0;
               total_in = MAG_W'(1);
               offset_in = '0;
               slice_in = MAG_W'(1);
               phase_in = 1'b1;
               first_in = 1'b1;
               failed_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= MAG_W'(1);
         offset_ff <= '0;
         slice_ff <= MAG_W'(1);
         phase_ff <= 1'b1;
         first_ff <= 1'b1;
         failed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         offset_ff <= offset_in;
         slice_ff <= slice_in;
         phase_ff <= phase_in;
         first_ff <= first_in;
         failed_ff <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dim_ff <= dim_in;
      idx_ff <= idx_in;
      has_idx_ff <= has_idx_in;
      last_ff <= last_in;
      ok_ff <= ok_in;
      off_res_ff <= off_res_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_slice_ff <= rsp_slice_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.ok = rsp_ok_ff;
   assign rsp_ch.offset = rsp_offset_ff;
   assign rsp_ch.slice_count = rsp_slice_ff;

   `TIO_ASSERT_IMP(a_done_in_wait, mul_res.done,
      state_ff == S_TOTAL_W || state_ff == S_PART_W || state_ff == S_FINAL_W,
      "multiply result outside a wait state")
   `TIO_ASSERT_NXT(a_load_resets_shape, state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready),
      rsp_valid_ff && first_ff && !failed_ff && state_ff == S_IDLE,
      "result load did not restart the shape")
   `TIO_ASSERT_IMP(a_fail_zeroes, rsp_valid_ff && !rsp_ok_ff,
      rsp_offset_ff == '0 && rsp_slice_ff == '0, "failed result carries nonzero payload")

endmodule

`default_nettype wire
